### design/vpe_pkg.sv
// Shared types and constants of the vertical-blank period estimator.
package vpe_pkg;

    localparam int EVT_W    = 48;   // event timestamp width
    localparam int PERIOD_W = 24;   // Q16.8 period width
    localparam int CNT_W    = 7;    // sample counter width
    localparam int CFG_W    = 16;   // widest register
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W   = 8;    // fraction bits of Q16.8

    localparam int CLAMP_BITS = 40;                 // interval clamp at 2**40 us
    localparam int DT_W       = CLAMP_BITS + 1;     // clamped interval width
    localparam int D_W        = DT_W + FRAC_W;      // interval in Q.8

    // shared divider: 28-bit dividend, 4-bit divisor, 4 quotient bits per cycle
    localparam int DIV_W      = 28;
    localparam int DVSR_W     = 4;
    localparam int DIV_RB     = 4;
    localparam int DIV_ITER   = DIV_W / DIV_RB;
    localparam int DIV_CNT_W  = $clog2(DIV_ITER + 1);

    localparam logic [DVSR_W-1:0] DIV_TEN  = 4'd10;
    localparam logic [DVSR_W-1:0] K_FIRST  = 4'd2;
    localparam logic [DVSR_W-1:0] K_LAST   = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES   = 2'd2;

    localparam logic [CFG_W-1:0] RST_MIN_INTERVAL = 16'd2000;
    localparam logic [CFG_W-1:0] RST_MAX_INTERVAL = 16'd60000;
    localparam logic [CNT_W-1:0] RST_MIN_SAMPLES  = 7'd8;

    localparam int CNT_MAX = 127;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_FOLD,
        ST_KSEARCH,
        ST_DIVK,
        ST_WINDOW,
        ST_DIV10,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;         // capture input word
        logic store_time;   // last time <= event time
        logic calc_dt;      // interval into d
        logic k_init;
        logic k_step;
        logic div_start_k;  // d / k
        logic div_start_10; // (9p + d) / 10
        logic div_step;
        logic fold_apply;   // d <= quotient
        logic count_clear;
        logic upd_seed;     // period <= d
        logic upd_avg;      // period <= quotient
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic ok;
        logic prev_zero;
        logic fold_hit;
        logic k_found;
        logic div_done;
        logic window_fail;
        logic period_zero;
        logic out_free;
    } t_dp_sts;

endpackage

### design/vpe_in_if.sv
// Input channel: one blank event word per handshake.
interface vpe_in_if;
    import vpe_pkg::*;

    logic             valid;
    logic             ready;
    logic [EVT_W-1:0] event_time_us;
    logic             wait_ok;

    modport source (output valid, output event_time_us, output wait_ok, input ready);
    modport sink   (input valid, input event_time_us, input wait_ok, output ready);
endinterface

### design/vpe_out_if.sv
// Output channel: one estimate word per handshake.
interface vpe_out_if;
    import vpe_pkg::*;

    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] period_q8;
    logic [EVT_W-1:0]    last_event_us;
    logic [CNT_W-1:0]    sample_count;
    logic                info_valid;

    modport source (output valid, output period_q8, output last_event_us,
                    output sample_count, output info_valid, input ready);
    modport sink   (input valid, input period_q8, input last_event_us,
                    input sample_count, input info_valid, output ready);
endinterface

### design/vblank_period_estimator.sv
// Vertical-blank period estimator. Each event word (timestamp, wait flag) yields one
// result word with the smoothed Q16.8 period, last event time, good-sample count and a
// validity flag. Words are handled one at a time: a failed wait or a first event goes
// straight to the result, an interval outside the window clears the count, one that
// seeds the period is stored, and one averaged into the period passes through the
// shared radix-16 divider; an interval near a multiple of the period is first folded
// back after the multiple search. The divider runs up to twice per word (interval /
// multiple, then the 9:1 average / 10). A result register sits on the output, so the
// next event word is taken while a finished result waits to be read.
module vblank_period_estimator #(
    parameter int SAMPLE_CAP = 64,
    parameter int TIME_BITS  = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    vpe_in_if.sink                        i_evt,
    vpe_out_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [vpe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vpe_pkg::CFG_W-1:0]     i_cfg_data
);
    import vpe_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    assign i_evt.ready = in_ready;

    vpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_evt.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vpe_datapath #(
        .SAMPLE_CAP (SAMPLE_CAP),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_evt_time      (i_evt.event_time_us),
        .i_evt_ok        (i_evt.wait_ok),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_period_q8     (o_res.period_q8),
        .o_last_event_us (o_res.last_event_us),
        .o_sample_count  (o_res.sample_count),
        .o_info_valid    (o_res.info_valid)
    );

endmodule

### design/vpe_ctrl.sv
// Sequencer of the period estimator: walks one event word through the datapath.
module vpe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  vpe_pkg::t_dp_sts  i_sts,
    output vpe_pkg::t_dp_cmd  o_cmd
);
    import vpe_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DELTA;
            end
            ST_DELTA: begin
                if (!i_sts.ok || i_sts.prev_zero) n_state = ST_OUT;
                else                              n_state = ST_FOLD;
            end
            ST_FOLD: begin
                n_state = i_sts.fold_hit ? ST_KSEARCH : ST_WINDOW;
            end
            ST_KSEARCH: begin
                if (i_sts.k_found) n_state = ST_DIVK;
            end
            ST_DIVK: begin
                if (i_sts.div_done) n_state = ST_WINDOW;
            end
            ST_WINDOW: begin
                if (i_sts.window_fail || i_sts.period_zero) n_state = ST_OUT;
                else                                        n_state = ST_DIV10;
            end
            ST_DIV10: begin
                if (i_sts.div_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DELTA: begin
                if (!i_sts.ok) begin
                    o_cmd.count_clear = 1'b1;
                end else begin
                    o_cmd.store_time = 1'b1;
                    o_cmd.calc_dt    = !i_sts.prev_zero;
                end
            end
            ST_FOLD: begin
                o_cmd.k_init = i_sts.fold_hit;
            end
            ST_KSEARCH: begin
                if (i_sts.k_found) o_cmd.div_start_k = 1'b1;
                else               o_cmd.k_step      = 1'b1;
            end
            ST_DIVK: begin
                if (i_sts.div_done) o_cmd.fold_apply = 1'b1;
                else                o_cmd.div_step   = 1'b1;
            end
            ST_WINDOW: begin
                if (i_sts.window_fail)      o_cmd.count_clear  = 1'b1;
                else if (i_sts.period_zero) o_cmd.upd_seed     = 1'b1;
                else                        o_cmd.div_start_10 = 1'b1;
            end
            ST_DIV10: begin
                if (i_sts.div_done) o_cmd.upd_avg  = 1'b1;
                else                o_cmd.div_step = 1'b1;
            end
            ST_OUT: begin
                o_cmd.out_load = i_sts.out_free;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded while output register busy");

    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.upd_seed, o_cmd.upd_avg, o_cmd.count_clear}))
        else $error("conflicting count/period updates");

    a_dt_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.calc_dt |-> (i_sts.ok && !i_sts.prev_zero))
        else $error("interval taken without a valid previous event");
`endif

endmodule

### design/vpe_datapath.sv
// Datapath of the period estimator: state, interval math, shared divider, output register.
module vpe_datapath #(
    parameter int SAMPLE_CAP = 64,
    parameter int TIME_BITS  = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vpe_pkg::t_dp_cmd                  i_cmd,
    output vpe_pkg::t_dp_sts                  o_sts,
    input  logic [vpe_pkg::EVT_W-1:0]         i_evt_time,
    input  logic                              i_evt_ok,
    input  logic                              i_cfg_we,
    input  logic [vpe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [vpe_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [vpe_pkg::PERIOD_W-1:0]      o_period_q8,
    output logic [vpe_pkg::EVT_W-1:0]         o_last_event_us,
    output logic [vpe_pkg::CNT_W-1:0]         o_sample_count,
    output logic                              o_info_valid
);
    import vpe_pkg::*;

    localparam int TW      = (TIME_BITS < EVT_W) ? TIME_BITS : EVT_W;
    localparam int CNT_LIM = (SAMPLE_CAP > CNT_MAX) ? CNT_MAX : SAMPLE_CAP;

    // configuration
    logic [CFG_W-1:0] r_min_int;
    logic [CFG_W-1:0] r_max_int;
    logic [CNT_W-1:0] r_min_smp;

    // estimator state
    logic [TW-1:0]       r_last_time;
    logic [PERIOD_W-1:0] r_period;
    logic [CNT_W-1:0]    r_count;

    // work registers
    logic [TW-1:0]        r_now;
    logic                 r_ok;
    logic [D_W-1:0]       r_d;
    logic [DVSR_W-1:0]    r_k;
    logic [DIV_W-1:0]     r_dq;
    logic [DVSR_W-1:0]    r_rem;
    logic [DVSR_W-1:0]    r_dvsr;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // output register
    logic                r_out_vld;
    logic [PERIOD_W-1:0] r_out_period;
    logic [EVT_W-1:0]    r_out_last;
    logic [CNT_W-1:0]    r_out_count;
    logic                r_out_info;

    // interval, modulo 2**TIME_BITS, clamped
    logic [TIME_BITS-1:0] dt;
    logic [63:0]          dt64;
    logic [DT_W-1:0]      dt_c;

    always_comb begin
        dt   = TIME_BITS'(r_now) - TIME_BITS'(r_last_time);
        dt64 = 64'(dt);
        if (dt64 > (64'd1 << CLAMP_BITS)) dt_c = DT_W'(64'd1 << CLAMP_BITS);
        else                              dt_c = dt64[DT_W-1:0];
    end

    // fold test: 3P < 2D < 17P
    logic [D_W:0] two_d;
    logic [D_W:0] three_p;
    logic [D_W:0] svnt_p;
    logic         fold_hit;

    assign two_d    = {r_d, 1'b0};
    assign three_p  = (D_W+1)'({r_period, 1'b0}) + (D_W+1)'(r_period);
    assign svnt_p   = (D_W+1)'({r_period, 4'b0}) + (D_W+1)'(r_period);
    assign fold_hit = (r_period != '0) && (two_d > three_p) && (two_d < svnt_p);

    // multiple search: k is the first m with 2D + P < 2P(m + 1); D < 2**28 here
    logic [DVSR_W-1:0] k_next;
    logic [29:0]       two_d_p;
    logic [29:0]       k_bound;

    assign k_next  = r_k + 4'd1;
    assign two_d_p = {r_d[DIV_W-1:0], 1'b0} + 30'(r_period);
    assign k_bound = 30'({r_period, 1'b0}) * 30'(k_next);

    // radix-16 restoring divider step
    logic [DVSR_W-1:0] div_rem_n;
    logic [DIV_W-1:0]  div_dq_n;

    always_comb begin
        logic [DVSR_W:0]   trial;
        logic [DVSR_W-1:0] rem;
        logic [DIV_W-1:0]  dq;
        rem = r_rem;
        dq  = r_dq;
        for (int i = 0; i < DIV_RB; i++) begin
            trial = {rem, dq[DIV_W-1]};
            dq    = {dq[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dvsr}) begin
                rem   = DVSR_W'(trial - {1'b0, r_dvsr});
                dq[0] = 1'b1;
            end else begin
                rem   = trial[DVSR_W-1:0];
            end
        end
        div_rem_n = rem;
        div_dq_n  = dq;
    end

    logic [DIV_W-1:0] avg_num;
    assign avg_num = DIV_W'({r_period, 3'b0}) + DIV_W'(r_period)
                   + DIV_W'(r_d[PERIOD_W-1:0]);

    logic window_fail;
    assign window_fail = (r_d < D_W'({r_min_int, 8'h00})) ||
                         (r_d > D_W'({r_max_int, 8'h00}));

    logic [CNT_W-1:0] count_inc;
    assign count_inc = (r_count < CNT_W'(CNT_LIM)) ? r_count + 7'd1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_int   <= RST_MIN_INTERVAL;
            r_max_int   <= RST_MAX_INTERVAL;
            r_min_smp   <= RST_MIN_SAMPLES;
            r_last_time <= '0;
            r_period    <= '0;
            r_count     <= '0;
            r_div_cnt   <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_INTERVAL: r_min_int <= i_cfg_data;
                    CFG_MAX_INTERVAL: r_max_int <= i_cfg_data;
                    CFG_MIN_SAMPLES:  r_min_smp <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.store_time) r_last_time <= r_now;

            if (i_cmd.count_clear) begin
                r_count <= '0;
            end else if (i_cmd.upd_seed) begin
                r_period <= r_d[PERIOD_W-1:0];
                r_count  <= count_inc;
            end else if (i_cmd.upd_avg) begin
                r_period <= r_dq[PERIOD_W-1:0];
                r_count  <= count_inc;
            end

            if (i_cmd.div_start_k || i_cmd.div_start_10) r_div_cnt <= '0;
            else if (i_cmd.div_step)                       r_div_cnt <= r_div_cnt + 1'b1;

            if (i_cmd.out_load)                     r_out_vld <= 1'b1;
            else if (r_out_vld && i_out_ready)      r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now <= i_evt_time[TW-1:0];
            r_ok  <= i_evt_ok;
        end

        if (i_cmd.calc_dt)         r_d <= {dt_c, {FRAC_W{1'b0}}};
        else if (i_cmd.fold_apply) r_d <= D_W'(r_dq);

        if (i_cmd.k_init)      r_k <= K_FIRST;
        else if (i_cmd.k_step) r_k <= k_next;

        if (i_cmd.div_start_k) begin
            r_dq   <= r_d[DIV_W-1:0];
            r_rem  <= '0;
            r_dvsr <= r_k;
        end else if (i_cmd.div_start_10) begin
            r_dq   <= avg_num;
            r_rem  <= '0;
            r_dvsr <= DIV_TEN;
        end else if (i_cmd.div_step) begin
            r_dq   <= div_dq_n;
            r_rem  <= div_rem_n;
        end

        if (i_cmd.out_load) begin
            r_out_period <= r_period;
            r_out_last   <= EVT_W'(r_last_time);
            r_out_count  <= r_count;
            r_out_info   <= (r_count >= r_min_smp) && (r_period != '0);
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.ok          = r_ok;
        o_sts.prev_zero   = (r_last_time == '0);
        o_sts.fold_hit    = fold_hit;
        o_sts.k_found     = (two_d_p < k_bound) || (r_k >= K_LAST);
        o_sts.div_done    = (r_div_cnt == DIV_CNT_W'(DIV_ITER));
        o_sts.window_fail = window_fail;
        o_sts.period_zero = (r_period == '0);
        o_sts.out_free    = !r_out_vld || i_out_ready;
    end

    assign o_out_valid     = r_out_vld;
    assign o_period_q8     = r_out_period;
    assign o_last_event_us = r_out_last;
    assign o_sample_count  = r_out_count;
    assign o_info_valid    = r_out_info;

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CNT_LIM))
        else $error("sample count past its cap");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fold_apply |-> (r_dvsr >= K_FIRST && r_dvsr <= K_LAST))
        else $error("fold multiple out of range");

    a_avg_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_avg |-> (r_dvsr == DIV_TEN && r_div_cnt == DIV_CNT_W'(DIV_ITER)))
        else $error("average taken from wrong or unfinished divide");
`endif

endmodule

### tb/vblank_period_estimator_tb.sv
`timescale 1ns / 100ps
// Testbench of the vertical-blank period estimator: directed and random blank events vs a predictor.
module vblank_period_estimator_tb;
    import vpe_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int SAMPLE_LIMIT = 64;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_q8;
        logic [EVT_W-1:0]    last_event_us;
        logic [CNT_W-1:0]    sample_count;
        logic                info_valid;
    } t_estimate;

    class period_scoreboard;
        logic [CFG_W-1:0]    min_interval;
        logic [CFG_W-1:0]    max_interval;
        logic [CNT_W-1:0]    min_samples;
        logic [EVT_W-1:0]    last_time;
        logic [PERIOD_W-1:0] period;
        logic [CNT_W-1:0]    good_count;
        t_estimate           estimate_q[$];
        int                  errors;

        function new();
            min_interval = RST_MIN_INTERVAL;
            max_interval = RST_MAX_INTERVAL;
            min_samples  = RST_MIN_SAMPLES;
            last_time    = '0;
            period       = '0;
            good_count   = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_MIN_INTERVAL: min_interval = val;
                CFG_MAX_INTERVAL: max_interval = val;
                CFG_MIN_SAMPLES:  min_samples  = val[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // fold near-multiples of the period back, window, then 9:1 smoothing
        function void take_interval(logic [EVT_W-1:0] delta);
            logic [63:0] d;
            logic [63:0] p;
            logic [63:0] k;
            logic [63:0] avg;
            d = 64'(delta);
            if (d > (64'd1 << CLAMP_BITS))
                d = 64'd1 << CLAMP_BITS;
            d = d << FRAC_W;
            p = 64'(period);
            if (p != 0 && 2 * d > 3 * p && 2 * d < 17 * p) begin
                k = (2 * d + p) / (2 * p);
                if (k != 0)
                    d = d / k;
            end
            if (d < (64'(min_interval) << FRAC_W) || d > (64'(max_interval) << FRAC_W)) begin
                good_count = '0;
                return;
            end
            avg = (9 * p + d) / 10;
            period = (p == 0) ? d[PERIOD_W-1:0] : avg[PERIOD_W-1:0];
            if (good_count < SAMPLE_LIMIT)
                good_count++;
        endfunction

        function void note_event(logic [EVT_W-1:0] t, logic ok);
            logic [EVT_W-1:0] prev;
            t_estimate        e;
            if (!ok) begin
                good_count = '0;
            end else begin
                prev = last_time;
                last_time = t;
                // stored time of zero means no reference yet
                if (prev != 0)
                    take_interval(t - prev);
            end
            e.period_q8     = period;
            e.last_event_us = last_time;
            e.sample_count  = good_count;
            e.info_valid    = (good_count >= min_samples) && (period != 0);
            estimate_q.push_back(e);
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch %s: expected %0h, got %0h", what, want, got);
        endfunction

        function void check_estimate(t_estimate got);
            t_estimate want;
            if (estimate_q.size() == 0) begin
                flag("unexpected word", '0, 64'(got));
                return;
            end
            want = estimate_q.pop_front();
            if (got.period_q8 !== want.period_q8)
                flag("period_q8", 64'(want.period_q8), 64'(got.period_q8));
            if (got.last_event_us !== want.last_event_us)
                flag("last_event_us", 64'(want.last_event_us), 64'(got.last_event_us));
            if (got.sample_count !== want.sample_count)
                flag("sample_count", 64'(want.sample_count), 64'(got.sample_count));
            if (got.info_valid !== want.info_valid)
                flag("info_valid", 64'(want.info_valid), 64'(got.info_valid));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    vpe_in_if  evt_if ();
    vpe_out_if res_if ();

    period_scoreboard sb;

    logic [EVT_W-1:0] cur_time    = '0;
    int               base_period = 16667;
    int               gap_max     = 3;
    int               burst_left  = 0;
    int               rx_mode     = RX_RANDOM;
    logic [7:0]       rx_pattern  = 8'hB5;
    bit               hold_req    = 1'b0;

    vblank_period_estimator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic send_word(input logic [EVT_W-1:0] t, input logic ok);
        int gap;
        evt_if.valid         <= 1'b1;
        evt_if.event_time_us <= t;
        evt_if.wait_ok       <= ok;
        @(posedge i_clk);
        while (!evt_if.ready)
            @(posedge i_clk);
        sb.note_event(t, ok);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                evt_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        evt_if.valid <= 1'b0;
        while (sb.estimate_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                input logic [CFG_W-1:0] need);
        wait_drained();
        cfg_write(CFG_MIN_INTERVAL, lo);
        cfg_write(CFG_MAX_INTERVAL, hi);
        cfg_write(CFG_MIN_SAMPLES, need);
        // unmapped index, must be ignored
        cfg_write(CFG_UNUSED, CFG_W'($urandom()));
        i_cfg_we <= 1'b0;
    endtask

    // mostly steady blank trains with jitter; some multiples, misfits, failures, noise
    task automatic run_random(input int n, input int pmin, input int pmax);
        int          r;
        int          step;
        int          jit;
        logic [63:0] wide;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            wide = {$urandom(), $urandom()};
            if (r < 4) begin
                send_word(wide[EVT_W-1:0], wide[63]);
            end else if (r < 8) begin
                send_word((r < 6) ? wide[EVT_W-1:0] : cur_time, 1'b0);
            end else if (r < 11) begin
                base_period = $urandom_range(pmin, pmax);
                cur_time = wide[62] ? {28'hFFF_FFFF, wide[19:0]} : wide[EVT_W-1:0];
                send_word(cur_time, 1'b1);
            end else begin
                jit = int'($urandom_range(0, base_period / 32)) - base_period / 64;
                if (r < 14)
                    step = $urandom_range(0, base_period / 2);
                else if (r < 16)
                    step = base_period * int'($urandom_range(9, 40));
                else if (r < 28)
                    step = base_period * int'($urandom_range(2, 8)) + jit;
                else
                    step = base_period + jit;
                cur_time = cur_time + step;
                send_word(cur_time, 1'b1);
            end
        end
    endtask

    // result side
    initial begin
        t_estimate got;
        int        tick;
        tick = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                got = {res_if.period_q8, res_if.last_event_us, res_if.sample_count,
                       res_if.info_valid};
                sb.check_estimate(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                case (rx_mode)
                    RX_ALWAYS: res_if.ready <= 1'b1;
                    RX_RANDOM: res_if.ready <= ($urandom_range(0, 99) < 55);
                    default:   res_if.ready <= rx_pattern[tick[2:0]];
                endcase
                tick++;
            end
        end
    end

    // watchdog: no word moving on either side for too long
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int fold_steps [6];
        fold_steps = '{1, 1, 2, 8, 9, 1};
        sb = new();
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= CFG_MIN_INTERVAL;
        i_cfg_data           <= '0;
        evt_if.valid         <= 1'b0;
        evt_if.event_time_us <= '0;
        evt_if.wait_ok       <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero time, failed wait at all ones, first event, seed, folds,
        // too long / too short, clamp, wraparound, then climb to the threshold
        send_word('0, 1'b1);
        send_word('1, 1'b0);
        cur_time = 48'd1000;
        send_word(cur_time, 1'b1);
        base_period = 16667;
        foreach (fold_steps[j]) begin
            cur_time = cur_time + base_period * fold_steps[j];
            send_word(cur_time, 1'b1);
        end
        cur_time = cur_time + 1000;
        send_word(cur_time, 1'b1);
        send_word(cur_time + 5, 1'b0);
        cur_time = cur_time + base_period;
        send_word(cur_time, 1'b1);
        cur_time = cur_time + 48'h2000_0000_0000;
        send_word(cur_time, 1'b1);
        cur_time = 48'hFFFF_FFFF_F000;
        send_word(cur_time, 1'b1);
        repeat (10) begin
            cur_time = cur_time + base_period;
            send_word(cur_time, 1'b1);
        end

        // reset settings; one pause until everything is out
        run_random(80, 4000, 40000);
        wait_drained();
        run_random(70, 4000, 40000);

        write_config(16'd0, 16'hFFFF, 16'd1);
        rx_mode = RX_ALWAYS;
        gap_max = 0;
        run_random(150, 1, 65535);

        write_config(16'd1000, 16'd20000, 16'd64);
        rx_mode = RX_PATTERN;
        rx_pattern = 8'($urandom_range(1, 255));
        gap_max = 6;
        run_random(170, 1500, 15000);

        // zero threshold: validity follows the period alone
        write_config(16'hFFFF, 16'hFFFF, 16'd0);
        rx_mode = RX_RANDOM;
        gap_max = 2;
        run_random(80, 64000, 65535);

        write_config(16'd0, 16'd0, 16'd127);
        run_random(60, 0, 4);

        // back to reset values; result side holds off while events keep coming
        write_config(RST_MIN_INTERVAL, RST_MAX_INTERVAL, 16'(RST_MIN_SAMPLES));
        gap_max = 0;
        run_random(20, 4000, 40000);
        hold_req = 1'b1;
        run_random(40, 4000, 40000);
        rx_mode = RX_PATTERN;
        gap_max = 8;
        run_random(90, 4000, 40000);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.estimate_q.size() != 0)
            sb.flag("words missing", 64'(sb.estimate_q.size()), '0);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
